// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset as disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Overlapping implication built on the clocked form.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== rtl/pta_pkg.sv =====
// Package: widths, constants, types and helpers of the point to pitch mapper.
`timescale 1ns / 1ps

package pta_pkg;

	localparam int VOICE_W = 3;
	localparam int X_W = 9;
	localparam int Y_W = 9;
	localparam int FREQ_W = 24;
	localparam int LOG_W = 16;
	localparam int RANGE_W = 16;
	localparam int DIV_W = 8;
	localparam int AMP_W = 17;
	localparam int CFG_W = FREQ_W;

	localparam int IMG_LOG2 = 9;
	localparam int IMG_SPAN = 1 << IMG_LOG2;
	localparam int MAX_VOICES = 8;
	localparam int AMP_SHIFT = 16 - IMG_LOG2;

	localparam int RX_W = RANGE_W + X_W;
	localparam int P2_W = RX_W + LOG_W;
	localparam int PLAIN_SH = IMG_LOG2 + 4;
	localparam int K_SH = IMG_LOG2 + 8;
	localparam int K_ROUND = 1 << (IMG_LOG2 + 7);
	localparam int K_W = DIV_W + RANGE_W + X_W + 1 - K_SH;
	localparam int KH_W = K_W + LOG_W;
	localparam int LOG_FRAC_SH = 4;

	localparam int DIV_STAGES = 5;
	localparam int DIV_STEPS = 8;
	localparam int NUM_W = DIV_STAGES * DIV_STEPS;

	localparam int FRAC_W = 16;
	localparam int INTERP_W = 12;
	localparam int SEG_W = FRAC_W - INTERP_W;
	localparam int TAB_IDX_W = SEG_W + 1;
	localparam int N_W = NUM_W - FRAC_W;
	localparam int M_W = 18;
	localparam int DIFF_W = 13;
	localparam int PROD_W = DIFF_W + INTERP_W;
	localparam int P_W = FREQ_W + M_W;
	localparam int SAT_EXP = FREQ_W;
	localparam int SH_W = 5;
	localparam int WIDE_W = P_W + SAT_EXP - 1;
	localparam int Q_W = WIDE_W - FRAC_W;
	localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

	localparam int PIPE_DEPTH = 4 + DIV_STAGES + 5;

	localparam logic [M_W-1:0] EXP2_TABLE [0:16] = '{
		18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
		18'd84990, 18'd88752, 18'd92682, 18'd96716, 18'd101070, 18'd105472,
		18'd110218, 18'd115175, 18'd120194, 18'd125515, 18'd131072
	};

	localparam int REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_START_FREQ      = 3'd0,
		REG_LOG2_RATIO      = 3'd1,
		REG_OCTAVE_RANGE    = 3'd2,
		REG_QUANTIZE_ENABLE = 3'd3,
		REG_NOTE_DIVISIONS  = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [FREQ_W-1:0]  start_freq;
		logic [LOG_W-1:0]   log2_ratio;
		logic [RANGE_W-1:0] octave_range;
		logic               quantize_enable;
		logic [DIV_W-1:0]   note_divisions;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		start_freq:      FREQ_W'(7040),
		log2_ratio:      LOG_W'(4096),
		octave_range:    RANGE_W'(512),
		quantize_enable: 1'b0,
		note_divisions:  DIV_W'(12)
	};

	typedef struct packed {
		logic [VOICE_W-1:0] voice;
		logic [AMP_W-1:0]   amp;
		logic [DIV_W-1:0]   divisor;
		logic [DIV_W-1:0]   rem;
		logic [NUM_W-1:0]   work;
	} div_word_t;

	function automatic logic [AMP_W-1:0] amp_of(input logic [Y_W-1:0] y);
		logic [AMP_W-1:0] span;
		if (AMP_W'(y) >= AMP_W'(IMG_SPAN)) begin
			return '0;
		end
		span = AMP_W'(IMG_SPAN) - AMP_W'(y);
		return span << AMP_SHIFT;
	endfunction

endpackage

// ===== rtl/point_to_pitch_amplitude.sv =====
// Top level of the point to pitch and amplitude mapper: registers and pipeline.
// Results: an accepted point passes the exponent, divider and power stages and comes out
// on the outputs with done high; the receiver takes every word and cannot stall.
// Throughput: one point per clock; the 14-stage pipeline, five of them the divider.
// Reset clears the pipeline valid flags and loads register defaults; busy holds high in reset
// and for the first cycle after it.
`timescale 1ns / 1ps

module point_to_pitch_amplitude import pta_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [VOICE_W-1:0]   tone_index,
	input  logic [X_W-1:0]       point_x,
	input  logic [Y_W-1:0]       point_y,
	output logic                 done,
	output logic [VOICE_W-1:0]   voice_index,
	output logic [FREQ_W-1:0]    frequency,
	output logic [AMP_W-1:0]     amplitude,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	cfg_t      cfg_q;
	logic      busy_q;
	logic      exp_valid, div_valid;
	div_word_t exp_word, div_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_START_FREQ:      cfg_q.start_freq <= cfg_wdata[FREQ_W-1:0];
				REG_LOG2_RATIO:      cfg_q.log2_ratio <= cfg_wdata[LOG_W-1:0];
				REG_OCTAVE_RANGE:    cfg_q.octave_range <= cfg_wdata[RANGE_W-1:0];
				REG_QUANTIZE_ENABLE: cfg_q.quantize_enable <= cfg_wdata[0];
				REG_NOTE_DIVISIONS:  cfg_q.note_divisions <= cfg_wdata[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;

	pta_exponent u_exponent (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start && !busy_q),
		.tone_index (tone_index),
		.point_x    (point_x),
		.point_y    (point_y),
		.cfg        (cfg_q),
		.out_valid  (exp_valid),
		.out_word   (exp_word)
	);

	pta_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (exp_valid),
		.in_word   (exp_word),
		.out_valid (div_valid),
		.out_word  (div_word)
	);

	pta_power u_power (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (div_valid),
		.in_word     (div_word),
		.cfg         (cfg_q),
		.done        (done),
		.voice_index (voice_index),
		.frequency   (frequency),
		.amplitude   (amplitude)
	);

endmodule

// ===== rtl/pta_exponent.sv =====
// Exponent front end: amplitude, scale products and divider operands, four stages.
`timescale 1ns / 1ps

module pta_exponent import pta_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [VOICE_W-1:0] tone_index,
	input  logic [X_W-1:0]     point_x,
	input  logic [Y_W-1:0]     point_y,
	input  cfg_t               cfg,
	output logic               out_valid,
	output div_word_t          out_word
);

	logic               voice_ok;
	logic [DIV_W-1:0]   d_eff;
	logic [LOG_W-1:0]   mulop;
	logic [P2_W-1:0]    p2;
	logic [P2_W:0]      k_sum;
	logic [KH_W-1:0]    kh;
	logic [RX_W-1:0]    rx;

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic [VOICE_W-1:0] voice_s1, voice_s2, voice_s3;
	logic [AMP_W-1:0]   amp_s1, amp_s2, amp_s3;
	logic [RX_W-1:0]    rx_s1;
	logic [P2_W-1:0]    p2_s2;
	logic [K_W-1:0]     k_s3;
	logic [NUM_W-1:0]   plain_s3;
	div_word_t          word_s4;

	always_comb begin
		voice_ok = (VOICE_W+1)'(tone_index) < (VOICE_W+1)'(MAX_VOICES);
		d_eff = (cfg.note_divisions == '0) ? DIV_W'(1) : cfg.note_divisions;
		mulop = cfg.quantize_enable ? LOG_W'(d_eff) : cfg.log2_ratio;
		rx = RX_W'(cfg.octave_range) * RX_W'(point_x);
		p2 = P2_W'(rx_s1) * P2_W'(mulop);
		k_sum = {1'b0, p2_s2} + (P2_W+1)'(K_ROUND);
		kh = KH_W'(k_s3) * KH_W'(cfg.log2_ratio);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && voice_ok;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		voice_s1 <= tone_index;
		amp_s1 <= amp_of(point_y);
		rx_s1 <= rx;

		voice_s2 <= voice_s1;
		amp_s2 <= amp_s1;
		p2_s2 <= p2;

		voice_s3 <= voice_s2;
		amp_s3 <= amp_s2;
		k_s3 <= K_W'(k_sum >> K_SH);
		plain_s3 <= NUM_W'(p2_s2 >> PLAIN_SH);

		word_s4.voice <= voice_s3;
		word_s4.amp <= amp_s3;
		word_s4.rem <= '0;
		word_s4.divisor <= cfg.quantize_enable ? d_eff : DIV_W'(1);
		word_s4.work <= cfg.quantize_enable ? (NUM_W'(kh) << LOG_FRAC_SH) : plain_s3;
	end

	assign out_valid = valid_s4;
	assign out_word = word_s4;

endmodule

// ===== rtl/pta_divider.sv =====
// Pipelined restoring divider for the scaled exponent, several quotient bits a stage.
`timescale 1ns / 1ps

module pta_divider import pta_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  div_word_t in_word,
	output logic      out_valid,
	output div_word_t out_word
);

	logic      valid_s [DIV_STAGES];
	div_word_t word_s [DIV_STAGES];

	function automatic div_word_t div_steps(input div_word_t w);
		div_word_t       r;
		logic [DIV_W:0]  trial;
		logic            ge;
		r = w;
		for (int j = 0; j < DIV_STEPS; j++) begin
			trial = {r.rem, r.work[NUM_W-1]};
			ge = trial >= {1'b0, r.divisor};
			if (ge) begin
				trial = trial - {1'b0, r.divisor};
			end
			r.rem = trial[DIV_W-1:0];
			r.work = {r.work[NUM_W-2:0], ge};
		end
		return r;
	endfunction

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		if (g == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[g] <= 1'b0;
				end else begin
					valid_s[g] <= in_valid;
				end
			end
			always_ff @(posedge clk) begin
				word_s[g] <= div_steps(in_word);
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[g] <= 1'b0;
				end else begin
					valid_s[g] <= valid_s[g-1];
				end
			end
			always_ff @(posedge clk) begin
				word_s[g] <= div_steps(word_s[g-1]);
			end
		end
	end

	assign out_valid = valid_s[DIV_STAGES-1];
	assign out_word = word_s[DIV_STAGES-1];

endmodule

// ===== rtl/pta_power.sv =====
// Power-of-two back end: table interpolation, frequency scaling and saturation.
`timescale 1ns / 1ps

module pta_power import pta_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  div_word_t          in_word,
	input  cfg_t               cfg,
	output logic               done,
	output logic [VOICE_W-1:0] voice_index,
	output logic [FREQ_W-1:0]  frequency,
	output logic [AMP_W-1:0]   amplitude
);

	logic [SEG_W-1:0]     seg;
	logic [TAB_IDX_W-1:0] idx_lo, idx_hi;
	logic [M_W-1:0]       diff_full;
	logic [WIDE_W-1:0]    wide;
	logic [Q_W-1:0]       q;
	logic                 over;
	logic [FREQ_W-1:0]    freq;

	logic                 valid_s10, valid_s11, valid_s12, valid_s13, valid_s14;
	logic [VOICE_W-1:0]   voice_s10, voice_s11, voice_s12, voice_s13, voice_s14;
	logic [AMP_W-1:0]     amp_s10, amp_s11, amp_s12, amp_s13, amp_s14;
	logic                 big_s10, big_s11, big_s12, big_s13;
	logic [SH_W-1:0]      sh_s10, sh_s11, sh_s12, sh_s13;
	logic [M_W-1:0]       base_s10, base_s11;
	logic [DIFF_W-1:0]    diff_s10;
	logic [INTERP_W-1:0]  frac_s10;
	logic [PROD_W-1:0]    prod_s11;
	logic [M_W-1:0]       m_s12;
	logic [P_W-1:0]       p_s13;
	logic [FREQ_W-1:0]    freq_s14;

	always_comb begin
		seg = in_word.work[FRAC_W-1:INTERP_W];
		idx_lo = {1'b0, seg};
		idx_hi = idx_lo + TAB_IDX_W'(1);
		diff_full = EXP2_TABLE[idx_hi] - EXP2_TABLE[idx_lo];

		wide = WIDE_W'(p_s13) << sh_s13;
		q = wide[WIDE_W-1:FRAC_W];
		over = |q[Q_W-1:FREQ_W];
		if (p_s13 == '0) begin
			freq = '0;
		end else if (big_s13 || over) begin
			freq = FREQ_MAX;
		end else begin
			freq = q[FREQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
			valid_s14 <= 1'b0;
		end else begin
			valid_s10 <= in_valid;
			valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
			valid_s13 <= valid_s12;
			valid_s14 <= valid_s13;
		end
	end

	always_ff @(posedge clk) begin
		voice_s10 <= in_word.voice;
		amp_s10 <= in_word.amp;
		big_s10 <= in_word.work[NUM_W-1:FRAC_W] >= N_W'(SAT_EXP);
		sh_s10 <= in_word.work[FRAC_W+SH_W-1:FRAC_W];
		base_s10 <= EXP2_TABLE[idx_lo];
		diff_s10 <= DIFF_W'(diff_full);
		frac_s10 <= in_word.work[INTERP_W-1:0];

		voice_s11 <= voice_s10;
		amp_s11 <= amp_s10;
		big_s11 <= big_s10;
		sh_s11 <= sh_s10;
		base_s11 <= base_s10;
		prod_s11 <= PROD_W'(diff_s10) * PROD_W'(frac_s10);

		voice_s12 <= voice_s11;
		amp_s12 <= amp_s11;
		big_s12 <= big_s11;
		sh_s12 <= sh_s11;
		m_s12 <= base_s11 + M_W'(prod_s11 >> INTERP_W);

		voice_s13 <= voice_s12;
		amp_s13 <= amp_s12;
		big_s13 <= big_s12;
		sh_s13 <= sh_s12;
		p_s13 <= P_W'(cfg.start_freq) * P_W'(m_s12);

		voice_s14 <= voice_s13;
		amp_s14 <= amp_s13;
		freq_s14 <= freq;
	end

	assign done = valid_s14;
	assign voice_index = voice_s14;
	assign frequency = freq_s14;
	assign amplitude = amp_s14;

endmodule

// ===== rtl/pta_checker.sv =====
// Port checker for the mapper and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pta_checker import pta_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic [VOICE_W-1:0]   tone_index,
	input logic [X_W-1:0]       point_x,
	input logic [Y_W-1:0]       point_y,
	input logic                 done,
	input logic [VOICE_W-1:0]   voice_index,
	input logic [FREQ_W-1:0]    frequency,
	input logic [AMP_W-1:0]     amplitude,
	input logic                 cfg_we,
	input logic [REG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0]     cfg_wdata
);

	`ASSERT_IMPLIES(a_word_has_point, clk, arst_n, done, $past(start && !busy && ((VOICE_W+1)'(tone_index) < (VOICE_W+1)'(MAX_VOICES)), PIPE_DEPTH), "result word without an accepted point")
	`ASSERT_IMPLIES(a_voice_follows, clk, arst_n, done, voice_index == $past(tone_index, PIPE_DEPTH), "voice index does not match its point")
	`ASSERT_IMPLIES(a_amp_follows, clk, arst_n, done, amplitude == amp_of($past(point_y, PIPE_DEPTH)), "amplitude does not match its point")

endmodule

bind point_to_pitch_amplitude pta_checker u_pta_checker (.*);
